>>> hw/rtl/order_maintenance_list_top_assert.svh
// Assertion macros for the order maintenance list.
// Included by the checker module; no other dependencies.
`ifndef ORDER_MAINTENANCE_LIST_TOP_ASSERT_SVH
`define ORDER_MAINTENANCE_LIST_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define OML_ASSERT_NOW(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("order maintenance list: assertion failed");

// Next-cycle implication, disabled while reset is high.
`define OML_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("order maintenance list: assertion failed");

`endif

>>> hw/rtl/oml_pkg.sv
// Shared constants and controller/datapath interface types for the
// order maintenance list. No dependencies.
package oml_pkg;

  localparam int NODE_COUNT_DEF    = 1024;
  localparam int FRACTION_BITS_DEF = 32;

  localparam int KIND_W  = 2;
  localparam int NODE_W  = 10;
  localparam int LABEL_W = 64;

  // request kinds; any other code is a label read
  localparam logic [KIND_W-1:0] KIND_AFTER  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BEFORE = 2'd1;

  // result source select
  localparam logic [1:0] OUT_ZERO = 2'd0;
  localparam logic [1:0] OUT_MID  = 2'd1;
  localparam logic [1:0] OUT_MEM  = 2'd2;

  typedef struct packed {
    logic       cap_req;    // capture request fields
    logic       init_step;  // write one reset entry, advance index
    logic       rd_u;       // read links of moved node
    logic       unlink;     // splice moved node out
    logic       rd_v;       // read links of anchor
    logic       link_a;     // point neighbors at node, read neighbor labels
    logic       link_b;     // write node links, form end labels
    logic       mid;        // write midpoint label
    logic       cnt_clr;    // start renumber walk at head
    logic       walk_wr;    // write rank label, read successor
    logic       walk_adv;   // step to successor
    logic       rd_lbl;     // read label of node
    logic       out_load;   // load result register
    logic [1:0] out_sel;
    logic       out_renum;
  } cmd_t;

  typedef struct packed {
    logic req_bad;        // node out of range
    logic req_move;       // valid move request
    logic mid_ok;         // midpoint strictly between neighbors
    logic idx_last;       // index at last node
    logic walk_has_next;  // walked node has a successor
  } status_t;

endpackage

>>> hw/rtl/oml_datapath.sv
// Datapath of the order maintenance list: link and label memories,
// head/tail registers, label arithmetic. Depends on oml_pkg.
module oml_datapath #(
  parameter int NODE_COUNT    = oml_pkg::NODE_COUNT_DEF,
  parameter int FRACTION_BITS = oml_pkg::FRACTION_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [oml_pkg::KIND_W-1:0]          kind,
  input  logic [oml_pkg::NODE_W-1:0]          node,
  input  logic [oml_pkg::NODE_W-1:0]          anchor,
  input  oml_pkg::cmd_t                       cmd,
  output oml_pkg::status_t                    stat,
  output logic signed [oml_pkg::LABEL_W-1:0]  label,
  output logic                                renumbered
);

  localparam int IDX_W = $clog2(NODE_COUNT);
  localparam int LNK_W = IDX_W + 1;
  localparam int RK_W  = IDX_W + 2;
  localparam int LW    = oml_pkg::LABEL_W;

  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(NODE_COUNT - 1);
  localparam logic [LW:0]      ONE_X     = (LW+1)'(1) << FRACTION_BITS;
  localparam logic [LW-1:0]    LABEL_MAX = {1'b0, {(LW-1){1'b1}}};
  localparam logic [LW-1:0]    LABEL_MIN = {1'b1, {(LW-1){1'b0}}};
  localparam logic [LW-1:0]    SAT_LIM   = LABEL_MAX >> (FRACTION_BITS - 1);

  // link entry: {flag, pointer}
  logic [LNK_W-1:0] next_mem  [NODE_COUNT];
  logic [LNK_W-1:0] prev_mem  [NODE_COUNT];
  logic [LW-1:0]    label_mem [NODE_COUNT];

  logic [IDX_W-1:0] u, v, head, tail, idx, walk_node;
  logic             ins_before;
  logic [LNK_W-1:0] next_rd, prev_rd;
  logic [LW-1:0]    lbl_rd_a, lbl_rd_b;
  logic [IDX_W-1:0] p, n;
  logic             hp, hn;
  logic [LW-1:0]    lp, ln;
  logic             sat;

  // request decode
  logic node_ok, anchor_ok;
  assign node_ok   = 32'(node) < NODE_COUNT;
  assign anchor_ok = 32'(anchor) < NODE_COUNT;

  // unlink view of moved node
  logic [IDX_W-1:0] p0, n0;
  logic             hp0, hn0;
  assign p0  = prev_rd[IDX_W-1:0];
  assign hp0 = prev_rd[IDX_W];
  assign n0  = next_rd[IDX_W-1:0];
  assign hn0 = next_rd[IDX_W];

  // new neighbors from anchor links
  logic [IDX_W-1:0] lk_p, lk_n;
  logic             lk_hp, lk_hn;
  assign lk_p  = ins_before ? prev_rd[IDX_W-1:0] : v;
  assign lk_hp = ins_before ? prev_rd[IDX_W] : 1'b1;
  assign lk_n  = ins_before ? v : next_rd[IDX_W-1:0];
  assign lk_hn = ins_before ? 1'b1 : next_rd[IDX_W];

  // reset-order neighbors of idx
  logic [IDX_W-1:0] idx_inc, idx_dec;
  assign idx_inc = (idx == LAST_IDX) ? '0 : idx + IDX_W'(1);
  assign idx_dec = (idx == '0) ? '0 : idx - IDX_W'(1);

  // rank label: (idx - N/2) in fixed point, saturated
  logic signed [RK_W-1:0] rk_h;
  logic [RK_W-1:0]        rk_m;
  logic [LW-1:0]          rk_mag, rank_lbl;
  assign rk_h   = $signed({1'b0, idx, 1'b0}) - $signed(RK_W'(NODE_COUNT));
  assign rk_m   = rk_h[RK_W-1] ? RK_W'(-rk_h) : RK_W'(rk_h);
  assign rk_mag = LW'(rk_m) << (FRACTION_BITS - 1);
  always_comb begin
    if (LW'(rk_m) > SAT_LIM) begin
      rank_lbl = rk_h[RK_W-1] ? LABEL_MIN : LABEL_MAX;
    end else begin
      rank_lbl = rk_h[RK_W-1] ? (~rk_mag + LW'(1)) : rk_mag;
    end
  end

  // end neighbor labels
  logic [LW:0] lp_dec, ln_inc;
  logic        lp_ovf, ln_ovf;
  assign lp_dec = {lbl_rd_a[LW-1], lbl_rd_a} - ONE_X;
  assign ln_inc = {lbl_rd_b[LW-1], lbl_rd_b} + ONE_X;
  assign lp_ovf = lp_dec[LW] != lp_dec[LW-1];
  assign ln_ovf = ln_inc[LW] != ln_inc[LW-1];

  // midpoint and gap: strictly between iff ln - lp >= 2
  logic [LW:0]   sum, diff;
  logic [LW-1:0] mid;
  assign sum  = {lp[LW-1], lp} + {ln[LW-1], ln};
  assign diff = {ln[LW-1], ln} - {lp[LW-1], lp};
  assign mid  = sum[LW:1];

  assign stat.req_bad       = !node_ok;
  assign stat.req_move      = ((kind == oml_pkg::KIND_AFTER) || (kind == oml_pkg::KIND_BEFORE))
                              && anchor_ok && (anchor != node);
  assign stat.mid_ok        = !sat && !diff[LW] && (|diff[LW-1:1]);
  assign stat.idx_last      = idx == LAST_IDX;
  assign stat.walk_has_next = next_rd[IDX_W];

  // next-link port
  logic             nx_we, nx_re;
  logic [IDX_W-1:0] nx_wa, nx_ra;
  logic [LNK_W-1:0] nx_wd;
  always_comb begin
    nx_we = 1'b0;
    nx_wa = '0;
    nx_wd = '0;
    if (cmd.init_step) begin
      nx_we = 1'b1;
      nx_wa = idx;
      nx_wd = {idx != LAST_IDX, idx_inc};
    end else if (cmd.unlink) begin
      nx_we = hp0;
      nx_wa = p0;
      nx_wd = {hn0, n0};
    end else if (cmd.link_a) begin
      nx_we = lk_hp;
      nx_wa = lk_p;
      nx_wd = {1'b1, u};
    end else if (cmd.link_b) begin
      nx_we = 1'b1;
      nx_wa = u;
      nx_wd = {hn, n};
    end
  end
  assign nx_re = cmd.rd_u | cmd.rd_v | cmd.walk_wr;
  assign nx_ra = cmd.rd_v ? v : (cmd.walk_wr ? walk_node : u);

  always_ff @(posedge clk) begin
    if (nx_we) begin
      next_mem[nx_wa] <= nx_wd;
    end
    if (nx_re) begin
      next_rd <= next_mem[nx_ra];
    end
  end

  // prev-link port
  logic             pv_we, pv_re;
  logic [IDX_W-1:0] pv_wa, pv_ra;
  logic [LNK_W-1:0] pv_wd;
  always_comb begin
    pv_we = 1'b0;
    pv_wa = '0;
    pv_wd = '0;
    if (cmd.init_step) begin
      pv_we = 1'b1;
      pv_wa = idx;
      pv_wd = {idx != '0, idx_dec};
    end else if (cmd.unlink) begin
      pv_we = hn0;
      pv_wa = n0;
      pv_wd = {hp0, p0};
    end else if (cmd.link_a) begin
      pv_we = lk_hn;
      pv_wa = lk_n;
      pv_wd = {1'b1, u};
    end else if (cmd.link_b) begin
      pv_we = 1'b1;
      pv_wa = u;
      pv_wd = {hp, p};
    end
  end
  assign pv_re = cmd.rd_u | cmd.rd_v;
  assign pv_ra = cmd.rd_v ? v : u;

  always_ff @(posedge clk) begin
    if (pv_we) begin
      prev_mem[pv_wa] <= pv_wd;
    end
    if (pv_re) begin
      prev_rd <= prev_mem[pv_ra];
    end
  end

  // label memory: one write, two reads
  logic             lb_we, lb_re_a;
  logic [IDX_W-1:0] lb_wa, lb_ra_a, lb_ra_b;
  logic [LW-1:0]    lb_wd;
  always_comb begin
    lb_we = 1'b0;
    lb_wa = '0;
    lb_wd = '0;
    if (cmd.init_step) begin
      lb_we = 1'b1;
      lb_wa = idx;
      lb_wd = rank_lbl;
    end else if (cmd.walk_wr) begin
      lb_we = 1'b1;
      lb_wa = walk_node;
      lb_wd = rank_lbl;
    end else if (cmd.mid) begin
      lb_we = 1'b1;
      lb_wa = u;
      lb_wd = mid;
    end
  end
  assign lb_re_a = cmd.link_a | cmd.rd_lbl;
  assign lb_ra_a = cmd.link_a ? (lk_hp ? lk_p : head) : u;
  assign lb_ra_b = lk_hn ? lk_n : tail;

  always_ff @(posedge clk) begin
    if (lb_we) begin
      label_mem[lb_wa] <= lb_wd;
    end
    if (lb_re_a) begin
      lbl_rd_a <= label_mem[lb_ra_a];
    end
    if (cmd.link_a) begin
      lbl_rd_b <= label_mem[lb_ra_b];
    end
  end

  // request capture and move working registers
  always_ff @(posedge clk) begin
    if (cmd.cap_req) begin
      u          <= IDX_W'(node);
      v          <= IDX_W'(anchor);
      ins_before <= kind == oml_pkg::KIND_BEFORE;
    end
    if (cmd.link_a) begin
      p  <= lk_p;
      hp <= lk_hp;
      n  <= lk_n;
      hn <= lk_hn;
    end
    if (cmd.link_b) begin
      lp  <= hp ? lbl_rd_a : (lp_ovf ? LABEL_MIN : lp_dec[LW-1:0]);
      ln  <= hn ? lbl_rd_b : (ln_ovf ? LABEL_MAX : ln_inc[LW-1:0]);
      sat <= (!hp && lp_ovf) || (!hn && ln_ovf);
    end
  end

  // list ends, sweep index, walk pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= LAST_IDX;
      idx       <= '0;
      walk_node <= '0;
    end else begin
      if (cmd.unlink) begin
        if (!hp0) begin
          head <= n0;
        end
        if (!hn0) begin
          tail <= p0;
        end
      end else if (cmd.link_a) begin
        if (!lk_hp) begin
          head <= u;
        end
        if (!lk_hn) begin
          tail <= u;
        end
      end
      if (cmd.cnt_clr) begin
        idx       <= '0;
        walk_node <= head;
      end else if (cmd.init_step) begin
        idx <= idx + IDX_W'(1);
      end else if (cmd.walk_adv) begin
        idx       <= idx + IDX_W'(1);
        walk_node <= next_rd[IDX_W-1:0];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (cmd.out_sel)
        oml_pkg::OUT_ZERO: label <= '0;
        oml_pkg::OUT_MID:  label <= mid;
        oml_pkg::OUT_MEM:  label <= lbl_rd_a;
        default:           label <= '0;
      endcase
      renumbered <= cmd.out_renum;
    end
  end

endmodule

>>> hw/rtl/oml_ctrl.sv
// Controller of the order maintenance list: sequences reset sweep, moves,
// renumber walk and label reads. Depends on oml_pkg.
module oml_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  oml_pkg::status_t  stat,
  output oml_pkg::cmd_t     cmd,
  output logic              busy,
  output logic              done
);

  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_RD_U   = 4'd2;
  localparam logic [3:0] ST_UNLINK = 4'd3;
  localparam logic [3:0] ST_RD_V   = 4'd4;
  localparam logic [3:0] ST_LINK_A = 4'd5;
  localparam logic [3:0] ST_LINK_B = 4'd6;
  localparam logic [3:0] ST_MID    = 4'd7;
  localparam logic [3:0] ST_W_WR   = 4'd8;
  localparam logic [3:0] ST_W_ADV  = 4'd9;
  localparam logic [3:0] ST_R_LBL  = 4'd10;
  localparam logic [3:0] ST_R_OUT  = 4'd11;

  logic [3:0] state, state_next;
  logic       renum, renum_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    renum_next = renum;
    case (state)
      ST_CLEAR: begin
        cmd.init_step = 1'b1;
        if (stat.idx_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.cap_req = 1'b1;
          renum_next  = 1'b0;
          if (stat.req_bad) begin
            cmd.out_load = 1'b1;
            cmd.out_sel  = oml_pkg::OUT_ZERO;
          end else if (stat.req_move) begin
            state_next = ST_RD_U;
          end else begin
            state_next = ST_R_LBL;
          end
        end
      end
      ST_RD_U: begin
        cmd.rd_u   = 1'b1;
        state_next = ST_UNLINK;
      end
      ST_UNLINK: begin
        cmd.unlink = 1'b1;
        state_next = ST_RD_V;
      end
      ST_RD_V: begin
        cmd.rd_v   = 1'b1;
        state_next = ST_LINK_A;
      end
      ST_LINK_A: begin
        cmd.link_a = 1'b1;
        state_next = ST_LINK_B;
      end
      ST_LINK_B: begin
        cmd.link_b = 1'b1;
        state_next = ST_MID;
      end
      ST_MID: begin
        cmd.mid = 1'b1;
        if (stat.mid_ok) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = oml_pkg::OUT_MID;
          state_next   = ST_IDLE;
        end else begin
          cmd.cnt_clr = 1'b1;
          renum_next  = 1'b1;
          state_next  = ST_W_WR;
        end
      end
      ST_W_WR: begin
        cmd.walk_wr = 1'b1;
        state_next  = ST_W_ADV;
      end
      ST_W_ADV: begin
        if (stat.walk_has_next && !stat.idx_last) begin
          cmd.walk_adv = 1'b1;
          state_next   = ST_W_WR;
        end else begin
          state_next = ST_R_LBL;
        end
      end
      ST_R_LBL: begin
        cmd.rd_lbl = 1'b1;
        state_next = ST_R_OUT;
      end
      ST_R_OUT: begin
        cmd.out_load  = 1'b1;
        cmd.out_sel   = oml_pkg::OUT_MEM;
        cmd.out_renum = renum;
        state_next    = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      renum <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      renum <= renum_next;
      done  <= cmd.out_load;
    end
  end

  assign busy = state != ST_IDLE;

endmodule

>>> hw/rtl/order_maintenance_list_top.sv
// Order maintenance list: a linked total order of NODE_COUNT nodes with
// fixed-point midpoint labels, renumbered from the head when a gap closes.
// Usage:
//  - Request channel: drive kind/node/anchor and raise start; the request is
//    taken at the rising edge where start is high and busy is low.
//    kind 0 moves node after anchor, kind 1 before anchor, other codes read
//    the label of node. A move onto itself or with anchor out of range is a
//    label read. A node out of range returns label 0.
//  - Result channel: done is high for exactly one cycle with label and
//    renumbered valid; the receiver cannot stall, so take it then.
//  - An out-of-range node is answered straight from idle; a label read
//    reads the label memory first. A move is a chain of dependent reads and
//    writes on the single-write link and label memories; one that renumbers
//    then walks the list from the head, node by node. One request at a time;
//    the next may be accepted in the cycle done is high.
//  - Reset (rst, synchronous): restores the identity order and its labels
//    by a sweep over all NODE_COUNT entries, one entry per cycle; busy stays
//    high until the sweep ends.
// Depends on oml_pkg, oml_datapath, oml_ctrl.
module order_maintenance_list_top #(
  parameter int NODE_COUNT    = oml_pkg::NODE_COUNT_DEF,
  parameter int FRACTION_BITS = oml_pkg::FRACTION_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [oml_pkg::KIND_W-1:0]          kind,
  input  logic [oml_pkg::NODE_W-1:0]          node,
  input  logic [oml_pkg::NODE_W-1:0]          anchor,
  output logic                                busy,
  output logic                                done,
  output logic signed [oml_pkg::LABEL_W-1:0]  label,
  output logic                                renumbered
);

  oml_pkg::cmd_t    cmd;   // controller -> datapath strobes
  oml_pkg::status_t stat;  // datapath -> controller flags

  // sequencer: reset sweep, move steps, renumber walk, result strobe
  oml_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // memories, list ends, label arithmetic, result register
  oml_datapath #(
    .NODE_COUNT    (NODE_COUNT),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .kind       (kind),
    .node       (node),
    .anchor     (anchor),
    .cmd        (cmd),
    .stat       (stat),
    .label      (label),
    .renumbered (renumbered)
  );

endmodule

>>> hw/rtl/oml_checker.sv
// Port-level checks for the order maintenance list, bound to the top level.
// Depends on oml_pkg and order_maintenance_list_top_assert.svh.
`include "order_maintenance_list_top_assert.svh"

module oml_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                start,
  input logic                                busy,
  input logic                                done,
  input logic signed [oml_pkg::LABEL_W-1:0]  label,
  input logic                                renumbered
);

  // a result is only shown once the block is free again
  `OML_ASSERT_NOW(a_done_idle, clk, rst, done, !busy)

  // an accepted request either starts work or answers at once
  `OML_ASSERT_NEXT(a_accept_acts, clk, rst, start && !busy, busy || done)

  // an immediate answer is the out-of-range result
  `OML_ASSERT_NOW(a_fast_zero, clk, rst, done && !$past(busy), label == '0 && !renumbered)

  // work begins only from an accepted request or from reset
  `OML_ASSERT_NOW(a_busy_cause, clk, rst, $rose(busy), $past(start) || $past(rst))

endmodule

bind order_maintenance_list_top oml_checker u_oml_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .label      (label),
  .renumbered (renumbered)
);
